// ===== design/dual_coil_wire_position_estimator_assert.svh =====
// Assertion macros shared by the wire position estimator modules.
`ifndef DUAL_COIL_WIRE_POSITION_ESTIMATOR_ASSERT_SVH
`define DUAL_COIL_WIRE_POSITION_ESTIMATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define DCWPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCWPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DCWPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define DCWPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/dcwpe_pkg.sv =====
// Shared types, constants and helpers of the wire position estimator.
package dcwpe_pkg;

    // Sample width default and side lanes
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int NUM_SIDES       = 2;
    localparam int SIDE_L          = 0;
    localparam int SIDE_R          = 1;

    // Calibration registers
    localparam int CAL_W     = 24;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_CAL_FAR   = 2'd0,
        REG_LEFT_CAL_NEAR  = 2'd1,
        REG_RIGHT_CAL_FAR  = 2'd2,
        REG_RIGHT_CAL_NEAR = 2'd3
    } t_cfg_reg;

    localparam logic [CAL_W-1:0] CAL_FAR_RST  = 24'h020000;  // 2.0 in Q8.16
    localparam logic [CAL_W-1:0] CAL_NEAR_RST = 24'h010000;  // 1.0 in Q8.16
    localparam logic [CAL_W-1:0] LIN_MAX      = 24'hFFFFFF;

    // Reciprocal: 2^(bits+18) / (9 * (2*s + 1)), rounded to nearest
    localparam int RECIP_SHIFT     = 18;
    localparam int RECIP_DEN_MUL   = 9;
    localparam int RECIP_DEN_EXTRA = 5;   // 9*(2s+1) needs bits+5
    localparam int RECIP_QUO_EXTRA = 15;  // quotient stays below 2^(bits+15)

    // Geometry in mm
    localparam int COIL_GAP       = 90;
    localparam int CAL_OFFSET     = 25;
    localparam int INVERSION_TRIM = -10;
    localparam int FULL_TURN      = 360;
    localparam int NEAR_MM        = COIL_GAP / 2 - CAL_OFFSET;
    localparam int FAR_MM         = COIL_GAP / 2 + CAL_OFFSET;
    localparam int MAP_GAIN       = (FAR_MM - NEAR_MM) * 256;

    // Linear map divider: |lin - near| * gain < 2^38
    localparam int MAP_NUM_W = 39;
    localparam int MAP_QUO_W = 38;
    localparam int MAP_DEN_W = CAL_W;

    // Signed Q23.8 results and a wide working width
    localparam int MM_W  = 32;
    localparam int SAT_W = 40;

    localparam logic signed [SAT_W-1:0] MM_HI           = 40'sh007FFFFFFF;
    localparam logic signed [SAT_W-1:0] MM_LO           = 40'shFF80000000;
    localparam logic signed [SAT_W-1:0] NEAR_Q8_S       = SAT_W'(NEAR_MM * 256);
    localparam logic signed [SAT_W-1:0] INVERT_LIMIT_S  =
        SAT_W'((COIL_GAP + INVERSION_TRIM) * 256);
    localparam logic signed [SAT_W-1:0] TURN_Q8_S       = SAT_W'(FULL_TURN * 256);

    // One result item
    typedef struct packed {
        logic signed [MM_W-1:0] left_mm;
        logic signed [MM_W-1:0] right_mm;
        logic signed [MM_W-1:0] displacement;
        logic signed [MM_W-1:0] heading;
        logic                   outside_wires;
        logic                   cal_fault;
    } t_result;

    // Clamp a wide signed value into 32 bits
    function automatic logic signed [MM_W-1:0] sat_mm(input logic signed [SAT_W-1:0] v);
        logic signed [MM_W-1:0] r;
        if (v > MM_HI) begin
            r = MM_HI[MM_W-1:0];
        end else if (v < MM_LO) begin
            r = MM_LO[MM_W-1:0];
        end else begin
            r = v[MM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/dcwpe_div_pipe.sv =====
// Two-lane restoring divider, one quotient bit per pipeline stage.
`include "dual_coil_wire_position_estimator_assert.svh"

module dcwpe_div_pipe
    import dcwpe_pkg::*;
#(
    parameter int NUM_W = MAP_NUM_W,
    parameter int DEN_W = MAP_DEN_W,
    parameter int QUO_W = MAP_QUO_W
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [NUM_W-1:0]     i_num [NUM_SIDES],
    input  logic [DEN_W-1:0]     i_den [NUM_SIDES],
    input  logic [NUM_SIDES-1:0] i_neg,
    output logic                 o_valid,
    output logic [QUO_W-1:0]     o_quo [NUM_SIDES],
    output logic [NUM_SIDES-1:0] o_neg
);

    // Dividend bits above the quotient; must stay below the divisor
    localparam int HEAD_W = NUM_W - QUO_W;

    logic [QUO_W-1:0]     r_valid;
    logic [DEN_W-1:0]     r_rem [QUO_W][NUM_SIDES];
    // upper part: dividend bits still to shift in, lower part: quotient bits
    logic [QUO_W-1:0]     r_lq  [QUO_W][NUM_SIDES];
    logic [DEN_W-1:0]     r_den [QUO_W][NUM_SIDES];
    logic [NUM_SIDES-1:0] r_neg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic                 valid_in;
        logic [NUM_SIDES-1:0] neg_in;
        logic [DEN_W-1:0]     rem_in [NUM_SIDES];
        logic [QUO_W-1:0]     lq_in  [NUM_SIDES];
        logic [DEN_W-1:0]     den_in [NUM_SIDES];
        logic [DEN_W-1:0]     n_rem  [NUM_SIDES];
        logic [QUO_W-1:0]     n_lq   [NUM_SIDES];

        // stage inputs: module ports for the first step, else the stage before
        if (k == 0) begin : g_first
            assign valid_in = i_valid;
            assign neg_in   = i_neg;
            for (genvar l = 0; l < NUM_SIDES; l++) begin : g_lane
                assign rem_in[l] = DEN_W'(i_num[l][NUM_W-1 -: HEAD_W]);
                assign lq_in[l]  = i_num[l][QUO_W-1:0];
                assign den_in[l] = i_den[l];
            end
        end else begin : g_next
            assign valid_in = r_valid[k-1];
            assign neg_in   = r_neg[k-1];
            for (genvar l = 0; l < NUM_SIDES; l++) begin : g_lane
                assign rem_in[l] = r_rem[k-1][l];
                assign lq_in[l]  = r_lq[k-1][l];
                assign den_in[l] = r_den[k-1][l];
            end
        end

        // one trial subtraction per lane
        for (genvar l = 0; l < NUM_SIDES; l++) begin : g_step
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;
            logic           ge;
            assign trial    = {rem_in[l], lq_in[l][QUO_W-1]};
            assign diff     = trial - {1'b0, den_in[l]};
            assign ge       = (trial >= {1'b0, den_in[l]});
            assign n_rem[l] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            assign n_lq[l]  = {lq_in[l][QUO_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k] <= neg_in;
                for (int l = 0; l < NUM_SIDES; l++) begin
                    r_rem[k][l] <= n_rem[l];
                    r_lq[k][l]  <= n_lq[l];
                    r_den[k][l] <= den_in[l];
                end
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_neg   = r_neg[QUO_W-1];
    for (genvar l = 0; l < NUM_SIDES; l++) begin : g_out
        assign o_quo[l] = r_lq[QUO_W-1][l];
    end

    // Remainder invariant on the last stage, and hold while the pipe is frozen
    for (genvar l = 0; l < NUM_SIDES; l++) begin : g_chk
        `DCWPE_ASSERT_IMP(a_rem_below_den, i_clk, i_rst_n,
            r_valid[QUO_W-1] && (r_den[QUO_W-1][l] != '0),
            r_rem[QUO_W-1][l] < r_den[QUO_W-1][l], "divider remainder not below divisor")
    end
    `DCWPE_ASSERT_NXT(a_hold_when_frozen, i_clk, i_rst_n, !i_en,
        $stable(o_valid) && $stable(o_neg), "divider output moved while frozen")

endmodule

// ===== design/dcwpe_mix.sv =====
// Outside-wire inversion, then displacement and heading, two stages.
module dcwpe_mix
    import dcwpe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [MM_W-1:0] i_left_mm,
    input  logic signed [MM_W-1:0] i_right_mm,
    input  logic                   i_cal_fault,
    output logic                   o_valid,
    output t_result                o_res
);

    logic                   r_i_valid;
    logic signed [MM_W-1:0] r_i_dl;
    logic signed [MM_W-1:0] r_i_dr;
    logic                   r_i_outside;
    logic                   r_i_fault;
    logic                   r_o_valid;
    t_result                r_o_res;

    logic signed [SAT_W-1:0] l_w;
    logic signed [SAT_W-1:0] r_w;
    logic                    inv_l;
    logic                    inv_r;
    logic signed [MM_W-1:0]  n_i_dl;
    logic signed [MM_W-1:0]  n_i_dr;

    // Stage 1: negate the shorter side when the other exceeds it by more than the limit
    always_comb begin
        l_w    = SAT_W'(i_left_mm);
        r_w    = SAT_W'(i_right_mm);
        inv_r  = (l_w - r_w) > INVERT_LIMIT_S;
        inv_l  = (r_w - l_w) > INVERT_LIMIT_S;
        n_i_dl = inv_l ? sat_mm(-l_w) : i_left_mm;
        n_i_dr = inv_r ? sat_mm(-r_w) : i_right_mm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (i_en) begin
            r_i_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i_dl      <= n_i_dl;
            r_i_dr      <= n_i_dr;
            r_i_outside <= inv_l | inv_r;
            r_i_fault   <= i_cal_fault;
        end
    end

    logic signed [SAT_W-1:0] dl_w;
    logic signed [SAT_W-1:0] dr_w;
    logic signed [SAT_W-1:0] diff_w;
    logic signed [SAT_W-1:0] half_w;
    logic signed [SAT_W-1:0] sum_w;
    logic signed [SAT_W-1:0] head_w;
    t_result                 n_o_res;

    // Stage 2: half difference toward zero, heading from the sum
    always_comb begin
        dl_w   = SAT_W'(r_i_dl);
        dr_w   = SAT_W'(r_i_dr);
        diff_w = dl_w - dr_w;
        half_w = (diff_w + $signed({{(SAT_W-1){1'b0}}, diff_w[SAT_W-1]})) >>> 1;
        sum_w  = dl_w + dr_w;
        head_w = (sum_w <<< 2) - TURN_Q8_S;

        n_o_res.left_mm       = r_i_dl;
        n_o_res.right_mm      = r_i_dr;
        n_o_res.displacement  = sat_mm(half_w);
        n_o_res.heading       = sat_mm(head_w);
        n_o_res.outside_wires = r_i_outside;
        n_o_res.cal_fault     = r_i_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_o_valid <= r_i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_res <= n_o_res;
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_o_res;

endmodule

// ===== design/dcwpe_out_buf.sv =====
// Output register plus skid entry; freezes the pipeline only when the skid is full.
`include "dual_coil_wire_position_estimator_assert.svh"

module dcwpe_out_buf
    import dcwpe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_en,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_stall
);

    logic    r_out_valid;
    t_result r_out_res;
    logic    r_skid_valid;
    t_result r_skid_res;

    logic    out_free;
    logic    n_out_valid;
    t_result n_out_res;
    logic    n_skid_valid;
    t_result n_skid_res;

    // Pipeline tail moves only while the skid is empty
    assign o_en     = !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_res    = r_out_res;
        n_skid_valid = r_skid_valid;
        n_skid_res   = r_skid_res;
        if (r_skid_valid) begin
            // drain the skid first
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_res    = r_skid_res;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_res   = i_res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_res   = i_res;
            end
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_res  <= n_out_res;
        r_skid_res <= n_skid_res;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out_res;

    // Skid is only ever used behind a waiting output item
    `DCWPE_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid holds an item while the output register is empty")
    `DCWPE_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_stall,
        r_out_valid && !r_skid_valid, "skid item not moved to output when taken")
    // A stalled result item stays valid and unchanged
    `DCWPE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_out_valid && i_stall,
        r_out_valid && $stable(o_res), "stalled output item changed")

endmodule

// ===== design/dual_coil_wire_position_estimator.sv =====
// Top level of the dual coil wire position estimator pipeline.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------------------
//  sample in | i_valid / o_stall     | i_left_sample, i_right_sample
//  result out| o_valid / i_stall     | o_left_mm, o_right_mm, o_displacement,
//            |                       | o_heading, o_outside_wires, o_cal_fault
//  config    | i_cfg_we              | i_cfg_index, i_cfg_data
//
// One item per cycle while o_stall is low. Most of the pipeline is the two
// bit-per-stage dividers: SAMPLE_BITS + 15 stages for the reciprocal, 38 for the map.
// Reset is synchronous: valid bits clear and the calibration points return to 1.0 / 2.0.
// A stalled result sits in the output register; one more item lands in a skid entry and
// only then does o_stall rise and the whole pipeline freeze.
module dual_coil_wire_position_estimator
    import dcwpe_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CAL_W-1:0]       i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_left_sample,
    input  logic [SAMPLE_BITS-1:0] i_right_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [MM_W-1:0] o_left_mm,
    output logic signed [MM_W-1:0] o_right_mm,
    output logic signed [MM_W-1:0] o_displacement,
    output logic signed [MM_W-1:0] o_heading,
    output logic                   o_outside_wires,
    output logic                   o_cal_fault
);

    localparam int RN_W   = SAMPLE_BITS + RECIP_SHIFT + 1;
    localparam int RD_W   = SAMPLE_BITS + RECIP_DEN_EXTRA;
    localparam int RQ_W   = SAMPLE_BITS + RECIP_QUO_EXTRA;
    localparam int LX_W   = (RQ_W > CAL_W) ? RQ_W : CAL_W;
    localparam int DIFF_W = CAL_W + 1;

    logic pipe_en;

    // Calibration registers
    logic [CAL_W-1:0] r_cal_far  [NUM_SIDES];
    logic [CAL_W-1:0] r_cal_near [NUM_SIDES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_SIDES; l++) begin
                r_cal_far[l]  <= CAL_FAR_RST;
                r_cal_near[l] <= CAL_NEAR_RST;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_LEFT_CAL_FAR:   r_cal_far[SIDE_L]  <= i_cfg_data;
                REG_LEFT_CAL_NEAR:  r_cal_near[SIDE_L] <= i_cfg_data;
                REG_RIGHT_CAL_FAR:  r_cal_far[SIDE_R]  <= i_cfg_data;
                REG_RIGHT_CAL_NEAR: r_cal_near[SIDE_R] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Prep stage: reciprocal divisor 9*(2s+1) and dividend with half-divisor rounding
    logic [SAMPLE_BITS-1:0] sample   [NUM_SIDES];
    logic [RD_W-1:0]        n_p_den  [NUM_SIDES];
    logic [RN_W-1:0]        n_p_num  [NUM_SIDES];
    logic                   r_p_valid;
    logic [RD_W-1:0]        r_p_den  [NUM_SIDES];
    logic [RN_W-1:0]        r_p_num  [NUM_SIDES];

    assign sample[SIDE_L] = i_left_sample;
    assign sample[SIDE_R] = i_right_sample;

    always_comb begin
        for (int l = 0; l < NUM_SIDES; l++) begin
            n_p_den[l] = RD_W'({sample[l], 1'b1}) * RD_W'(RECIP_DEN_MUL);
            n_p_num[l] = (RN_W'(1) << (SAMPLE_BITS + RECIP_SHIFT)) + RN_W'(n_p_den[l] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (pipe_en) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int l = 0; l < NUM_SIDES; l++) begin
                r_p_den[l] <= n_p_den[l];
                r_p_num[l] <= n_p_num[l];
            end
        end
    end

    // Reciprocal divider
    logic            d1_valid;
    logic [RQ_W-1:0] d1_quo [NUM_SIDES];

    dcwpe_div_pipe #(
        .NUM_W (RN_W),
        .DEN_W (RD_W),
        .QUO_W (RQ_W)
    ) u_recip_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_p_valid),
        .i_num   (r_p_num),
        .i_den   (r_p_den),
        .i_neg   ('0),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_neg   ()
    );

    // Map stage A: clamp to Q8.16, subtract the near point
    logic [LX_W-1:0]          a_qx     [NUM_SIDES];
    logic [CAL_W-1:0]         a_lin    [NUM_SIDES];
    logic signed [DIFF_W-1:0] n_a_diff [NUM_SIDES];
    logic                     r_a_valid;
    logic signed [DIFF_W-1:0] r_a_diff [NUM_SIDES];

    always_comb begin
        for (int l = 0; l < NUM_SIDES; l++) begin
            a_qx[l]     = LX_W'(d1_quo[l]);
            a_lin[l]    = (a_qx[l] > LX_W'(LIN_MAX)) ? LIN_MAX : a_qx[l][CAL_W-1:0];
            n_a_diff[l] = $signed({1'b0, a_lin[l]}) - $signed({1'b0, r_cal_near[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (pipe_en) begin
            r_a_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int l = 0; l < NUM_SIDES; l++) begin
                r_a_diff[l] <= n_a_diff[l];
            end
        end
    end

    // Map stage B: magnitudes, scale by the mm span, quotient sign
    logic signed [DIFF_W-1:0] b_abs    [NUM_SIDES];
    logic signed [DIFF_W-1:0] b_span   [NUM_SIDES];
    logic signed [DIFF_W-1:0] b_span_a [NUM_SIDES];
    logic [MAP_NUM_W-1:0]     n_b_num  [NUM_SIDES];
    logic [MAP_DEN_W-1:0]     n_b_den  [NUM_SIDES];
    logic [NUM_SIDES-1:0]     n_b_neg;
    logic                     r_b_valid;
    logic [MAP_NUM_W-1:0]     r_b_num  [NUM_SIDES];
    logic [MAP_DEN_W-1:0]     r_b_den  [NUM_SIDES];
    logic [NUM_SIDES-1:0]     r_b_neg;

    always_comb begin
        for (int l = 0; l < NUM_SIDES; l++) begin
            b_abs[l]    = r_a_diff[l][DIFF_W-1] ? -r_a_diff[l] : r_a_diff[l];
            b_span[l]   = $signed({1'b0, r_cal_far[l]}) - $signed({1'b0, r_cal_near[l]});
            b_span_a[l] = b_span[l][DIFF_W-1] ? -b_span[l] : b_span[l];
            n_b_num[l]  = MAP_NUM_W'(b_abs[l][CAL_W-1:0]) * MAP_NUM_W'(MAP_GAIN);
            n_b_den[l]  = b_span_a[l][MAP_DEN_W-1:0];
            n_b_neg[l]  = r_a_diff[l][DIFF_W-1] ^ b_span[l][DIFF_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (pipe_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_b_neg <= n_b_neg;
            for (int l = 0; l < NUM_SIDES; l++) begin
                r_b_num[l] <= n_b_num[l];
                r_b_den[l] <= n_b_den[l];
            end
        end
    end

    // Linear map divider
    logic                 d2_valid;
    logic [MAP_QUO_W-1:0] d2_quo [NUM_SIDES];
    logic [NUM_SIDES-1:0] d2_neg;

    dcwpe_div_pipe #(
        .NUM_W (MAP_NUM_W),
        .DEN_W (MAP_DEN_W),
        .QUO_W (MAP_QUO_W)
    ) u_map_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_b_valid),
        .i_num   (r_b_num),
        .i_den   (r_b_den),
        .i_neg   (r_b_neg),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_neg   (d2_neg)
    );

    // Post stage: apply sign, add the near distance, clamp; equal points give zero
    logic signed [SAT_W-1:0] m_qmag  [NUM_SIDES];
    logic signed [SAT_W-1:0] m_sum   [NUM_SIDES];
    logic [NUM_SIDES-1:0]    m_fault;
    logic signed [MM_W-1:0]  n_m_mm  [NUM_SIDES];
    logic                    r_m_valid;
    logic signed [MM_W-1:0]  r_m_mm  [NUM_SIDES];
    logic                    r_m_fault;

    always_comb begin
        for (int l = 0; l < NUM_SIDES; l++) begin
            m_qmag[l]  = SAT_W'(d2_quo[l]);
            m_sum[l]   = (d2_neg[l] ? -m_qmag[l] : m_qmag[l]) + NEAR_Q8_S;
            m_fault[l] = (r_cal_far[l] == r_cal_near[l]);
            n_m_mm[l]  = m_fault[l] ? '0 : sat_mm(m_sum[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (pipe_en) begin
            r_m_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_m_fault <= |m_fault;
            for (int l = 0; l < NUM_SIDES; l++) begin
                r_m_mm[l] <= n_m_mm[l];
            end
        end
    end

    // Inversion, displacement and heading
    logic    mix_valid;
    t_result mix_res;

    dcwpe_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_valid     (r_m_valid),
        .i_left_mm   (r_m_mm[SIDE_L]),
        .i_right_mm  (r_m_mm[SIDE_R]),
        .i_cal_fault (r_m_fault),
        .o_valid     (mix_valid),
        .o_res       (mix_res)
    );

    // Output register and skid
    t_result out_res;

    dcwpe_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .i_res   (mix_res),
        .o_en    (pipe_en),
        .o_valid (o_valid),
        .o_res   (out_res),
        .i_stall (i_stall)
    );

    assign o_stall         = !pipe_en;
    assign o_left_mm       = out_res.left_mm;
    assign o_right_mm      = out_res.right_mm;
    assign o_displacement  = out_res.displacement;
    assign o_heading       = out_res.heading;
    assign o_outside_wires = out_res.outside_wires;
    assign o_cal_fault     = out_res.cal_fault;

endmodule

// ===== tb/sv/dual_coil_wire_position_estimator_tb.sv =====
// Self-checking testbench for the dual coil wire position estimator.
module dual_coil_wire_position_estimator_tb
    import dcwpe_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_W      = SAMPLE_BITS_DEF;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 215;
    localparam int TAIL_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 40;

    // Geometry in Q.8 mm, kept apart from the design's own constants
    localparam longint NEAR_Q8   = 20 * 256;
    localparam longint SPAN_Q8   = 50 * 256;
    localparam longint INVERT_Q8 = 80 * 256;
    localparam longint TURN_Q8   = 360 * 256;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;
    localparam longint RECIP_NUM = 64'd1 << (CODE_W + 18);

    localparam logic [CAL_W-1:0] C_ZERO = '0;
    localparam logic [CAL_W-1:0] C_TOP  = 24'hFFFFFF;
    localparam logic [CAL_W-1:0] C_TOP1 = 24'hFFFFFE;
    localparam logic [CAL_W-1:0] C_MID  = 24'h008000;

    // Results that follow directly from the geometry
    localparam t_result RES_FAULT = '{left_mm: 32'sd0, right_mm: 32'sd0,
                                      displacement: 32'sd0, heading: -32'sd92160,
                                      outside_wires: 1'b0, cal_fault: 1'b1};
    localparam t_result RES_NEAR  = '{left_mm: 32'sd5120, right_mm: 32'sd5120,
                                      displacement: 32'sd0, heading: -32'sd51200,
                                      outside_wires: 1'b0, cal_fault: 1'b0};
    localparam t_result RES_FAR   = '{left_mm: 32'sd17920, right_mm: 32'sd17920,
                                      displacement: 32'sd0, heading: 32'sd51200,
                                      outside_wires: 1'b0, cal_fault: 1'b0};

    typedef enum {CAL_TYPICAL, CAL_SWAPPED, CAL_EXTREME, CAL_RANDOM, CAL_ONE_EQUAL,
                  CAL_DEFAULT} t_cal_kind;

    // One directed row: calibration, sample pair, optional fixed result
    typedef struct {
        logic [CAL_W-1:0]  lf, ln, rf, rn;
        logic [CODE_W-1:0] l, r;
        bit                typed;
        t_result           want;
    } t_vec_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CAL_W-1:0]       i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic [CODE_W-1:0]      i_left_sample;
    logic [CODE_W-1:0]      i_right_sample;
    logic                   o_valid;
    logic                   i_stall;
    logic signed [MM_W-1:0] o_left_mm;
    logic signed [MM_W-1:0] o_right_mm;
    logic signed [MM_W-1:0] o_displacement;
    logic signed [MM_W-1:0] o_heading;
    logic                   o_outside_wires;
    logic                   o_cal_fault;

    logic [CAL_W-1:0] cal_pts [4];
    t_result          pos_expect_q [$];
    t_vec_row         vec_rows [$];
    int               mismatch_count = 0;
    int               items_sent     = 0;
    int               results_checked = 0;
    int               outside_seen   = 0;
    int               fault_seen     = 0;
    int               cal_settings   = 0;
    int               rx_stall_pct   = 0;
    int               cycle_count    = 0;

    dual_coil_wire_position_estimator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_left_sample   (i_left_sample),
        .i_right_sample  (i_right_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_left_mm       (o_left_mm),
        .o_right_mm      (o_right_mm),
        .o_displacement  (o_displacement),
        .o_heading       (o_heading),
        .o_outside_wires (o_outside_wires),
        .o_cal_fault     (o_cal_fault)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_s32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // Volts reciprocal in Q8.16, rounded half up, clipped to 24 bits
    function automatic logic [CAL_W-1:0] coil_recip(input logic [CODE_W-1:0] code);
        longint den;
        longint q;
        den = 9 * (2 * longint'(code) + 1);
        q = (RECIP_NUM + den / 2) / den;
        if (q > longint'(C_TOP)) q = longint'(C_TOP);
        return q[CAL_W-1:0];
    endfunction

    // Two-point line: near point is 20 mm, far point is 70 mm
    function automatic longint coil_distance(input logic [CAL_W-1:0] lin,
                                             input logic [CAL_W-1:0] near_pt,
                                             input logic [CAL_W-1:0] far_pt);
        longint span;
        span = longint'(far_pt) - longint'(near_pt);
        if (span == 0) return 0;
        return clamp_s32((longint'(lin) - longint'(near_pt)) * SPAN_Q8 / span + NEAR_Q8);
    endfunction

    function automatic t_result predict_position(input logic [CODE_W-1:0] l,
                                                 input logic [CODE_W-1:0] r);
        t_result res;
        longint  lmm, rmm, dl, dr;
        lmm = coil_distance(coil_recip(l), cal_pts[REG_LEFT_CAL_NEAR],
                            cal_pts[REG_LEFT_CAL_FAR]);
        rmm = coil_distance(coil_recip(r), cal_pts[REG_RIGHT_CAL_NEAR],
                            cal_pts[REG_RIGHT_CAL_FAR]);
        dl = lmm;
        dr = rmm;
        res.outside_wires = 1'b0;
        res.cal_fault = (cal_pts[REG_LEFT_CAL_NEAR] == cal_pts[REG_LEFT_CAL_FAR]) ||
                        (cal_pts[REG_RIGHT_CAL_NEAR] == cal_pts[REG_RIGHT_CAL_FAR]);
        // Outside the wires: flip the side that is far too short; the test
        // uses the distances before either flip
        if (lmm - rmm > INVERT_Q8) begin
            dr = clamp_s32(-rmm);
            res.outside_wires = 1'b1;
        end
        if (rmm - lmm > INVERT_Q8) begin
            dl = clamp_s32(-lmm);
            res.outside_wires = 1'b1;
        end
        res.left_mm      = dl[MM_W-1:0];
        res.right_mm     = dr[MM_W-1:0];
        res.displacement = MM_W'(clamp_s32((dl - dr) / 2));
        res.heading      = MM_W'(clamp_s32(4 * (dl + dr) - TURN_Q8));
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] item %0d: %s got %0d expected %0d",
                     $realtime, results_checked, what, got, want);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pos_expect_q.size() == 0) begin
                report_mismatch("result with nothing pending", longint'(0), longint'(0));
            end else begin
                want = pos_expect_q.pop_front();
                if (o_left_mm !== want.left_mm)
                    report_mismatch("left_mm", longint'(o_left_mm),
                                    longint'(want.left_mm));
                if (o_right_mm !== want.right_mm)
                    report_mismatch("right_mm", longint'(o_right_mm),
                                    longint'(want.right_mm));
                if (o_displacement !== want.displacement)
                    report_mismatch("displacement", longint'(o_displacement),
                                    longint'(want.displacement));
                if (o_heading !== want.heading)
                    report_mismatch("heading", longint'(o_heading),
                                    longint'(want.heading));
                if (o_outside_wires !== want.outside_wires)
                    report_mismatch("outside_wires", longint'(o_outside_wires),
                                    longint'(want.outside_wires));
                if (o_cal_fault !== want.cal_fault)
                    report_mismatch("cal_fault", longint'(o_cal_fault),
                                    longint'(want.cal_fault));
                outside_seen += want.outside_wires;
                fault_seen += want.cal_fault;
                results_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers

    // Mostly short gaps, now and then a long one
    function automatic int gap_length(input int idle_pct);
        int r;
        if ($urandom_range(0, 99) >= idle_pct) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] ones;
        ones = '1;
        if ($urandom_range(0, 9) != 0) return CODE_W'($urandom);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return CODE_W'(1);
            2: return ones;
            3: return ones - CODE_W'(1);
            default: return CODE_W'(1 << (CODE_W - 1));
        endcase
    endfunction

    function automatic logic [CAL_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return C_ZERO;
            1: return C_TOP;
            2: return C_TOP1;
            default: return CAL_W'($urandom);
        endcase
    endfunction

    // Drive one item and hold it until it is taken; then idle for the given gap
    task automatic send_pair(input logic [CODE_W-1:0] l, input logic [CODE_W-1:0] r,
                             input bit typed, input t_result want, input int gap);
        i_valid = 1'b1;
        i_left_sample = l;
        i_right_sample = r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pos_expect_q.push_back(typed ? want : predict_position(l, r));
        items_sent++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) begin
                i_left_sample = CODE_W'($urandom);
                i_right_sample = CODE_W'($urandom);
                @(negedge i_clk);
            end
        end
    endtask

    // Stop sending and wait until every pending result has come out
    task automatic wait_drained();
        i_valid = 1'b0;
        while (pos_expect_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cal_reg(input t_cfg_reg idx, input logic [CAL_W-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        cal_pts[idx] = val;
        @(negedge i_clk);
    endtask

    task automatic program_cal(input logic [CAL_W-1:0] lf, input logic [CAL_W-1:0] ln,
                               input logic [CAL_W-1:0] rf, input logic [CAL_W-1:0] rn);
        wait_drained();
        write_cal_reg(REG_LEFT_CAL_FAR, lf);
        write_cal_reg(REG_LEFT_CAL_NEAR, ln);
        write_cal_reg(REG_RIGHT_CAL_FAR, rf);
        write_cal_reg(REG_RIGHT_CAL_NEAR, rn);
        i_cfg_we = 1'b0;
        cal_settings++;
    endtask

    task automatic choose_cal(input int phase, output logic [CAL_W-1:0] lf,
                              output logic [CAL_W-1:0] ln, output logic [CAL_W-1:0] rf,
                              output logic [CAL_W-1:0] rn);
        t_cal_kind kind;
        if (phase == 0) kind = CAL_TYPICAL;
        else if (phase == 1) kind = CAL_EXTREME;
        else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kind = CAL_TYPICAL;
                4: kind = CAL_SWAPPED;
                5: kind = CAL_EXTREME;
                6: kind = CAL_RANDOM;
                7, 8: kind = CAL_ONE_EQUAL;
                default: kind = CAL_DEFAULT;
            endcase
        end
        // Near points from strong samples, far points from weak ones
        ln = coil_recip(CODE_W'($urandom_range(300, 1023)));
        lf = coil_recip(CODE_W'($urandom_range(20, 299)));
        rn = coil_recip(CODE_W'($urandom_range(300, 1023)));
        rf = coil_recip(CODE_W'($urandom_range(20, 299)));
        case (kind)
            CAL_SWAPPED: begin
                {ln, lf} = {lf, ln};
                {rn, rf} = {rf, rn};
            end
            CAL_EXTREME: begin
                lf = pick_extreme();
                ln = pick_extreme();
                rf = pick_extreme();
                rn = pick_extreme();
            end
            CAL_RANDOM: begin
                lf = CAL_W'($urandom);
                ln = CAL_W'($urandom);
                rf = CAL_W'($urandom);
                rn = CAL_W'($urandom);
            end
            CAL_ONE_EQUAL: begin
                if ($urandom_range(0, 1)) lf = ln;
                else rf = rn;
            end
            CAL_DEFAULT: begin
                lf = CAL_FAR_RST;
                ln = CAL_NEAR_RST;
                rf = CAL_FAR_RST;
                rn = CAL_NEAR_RST;
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- result side stalls

    initial begin : result_stalls
        int stall_run;
        i_stall = 1'b0;
        stall_run = 0;
        forever begin
            @(negedge i_clk);
            if (stall_run > 0) begin
                stall_run--;
            end else begin
                i_stall = ($urandom_range(0, 99) < rx_stall_pct);
                stall_run = gap_length(100) - 1;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin : stimulus
        logic [CAL_W-1:0] lf, ln, rf, rn;
        logic [CAL_W-1:0] typ_near, typ_far;
        int               tx_idle_pct;
        t_vec_row         row;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_LEFT_CAL_FAR;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_left_sample = '0;
        i_right_sample = '0;
        cal_pts[REG_LEFT_CAL_FAR] = CAL_FAR_RST;
        cal_pts[REG_LEFT_CAL_NEAR] = CAL_NEAR_RST;
        cal_pts[REG_RIGHT_CAL_FAR] = CAL_FAR_RST;
        cal_pts[REG_RIGHT_CAL_NEAR] = CAL_NEAR_RST;
        typ_near = coil_recip(CODE_W'(600));
        typ_far = coil_recip(CODE_W'(150));

        // Directed rows: reset calibration first, then corner settings
        vec_rows.push_back('{CAL_FAR_RST, CAL_NEAR_RST, CAL_FAR_RST, CAL_NEAR_RST,
                             10'd0, 10'd0, 1'b0, '0});
        vec_rows.push_back('{CAL_FAR_RST, CAL_NEAR_RST, CAL_FAR_RST, CAL_NEAR_RST,
                             10'd1023, 10'd1023, 1'b0, '0});
        vec_rows.push_back('{CAL_FAR_RST, CAL_NEAR_RST, CAL_FAR_RST, CAL_NEAR_RST,
                             10'd0, 10'd1023, 1'b0, '0});
        vec_rows.push_back('{CAL_FAR_RST, CAL_NEAR_RST, CAL_FAR_RST, CAL_NEAR_RST,
                             10'd1023, 10'd0, 1'b0, '0});
        vec_rows.push_back('{CAL_FAR_RST, CAL_NEAR_RST, CAL_FAR_RST, CAL_NEAR_RST,
                             10'd1, 10'd512, 1'b0, '0});
        vec_rows.push_back('{CAL_FAR_RST, CAL_NEAR_RST, CAL_FAR_RST, CAL_NEAR_RST,
                             10'd341, 10'd682, 1'b0, '0});
        vec_rows.push_back('{CAL_FAR_RST, CAL_NEAR_RST, CAL_FAR_RST, CAL_NEAR_RST,
                             10'd682, 10'd341, 1'b0, '0});
        // Saturated reciprocal lands exactly on the near point
        vec_rows.push_back('{C_ZERO, C_TOP, C_ZERO, C_TOP, 10'd0, 10'd0, 1'b1, RES_NEAR});
        vec_rows.push_back('{C_ZERO, C_TOP, C_ZERO, C_TOP, 10'd1023, 10'd0, 1'b0, '0});
        vec_rows.push_back('{C_ZERO, C_TOP, C_ZERO, C_TOP, 10'd0, 10'd1023, 1'b0, '0});
        // ... and on the far point
        vec_rows.push_back('{C_TOP, C_ZERO, C_TOP, C_ZERO, 10'd0, 10'd0, 1'b1, RES_FAR});
        vec_rows.push_back('{C_TOP, C_ZERO, C_TOP, C_ZERO, 10'd1023, 10'd1023, 1'b0, '0});
        // Equal calibration points on both sides
        vec_rows.push_back('{C_MID, C_MID, C_MID, C_MID, 10'd0, 10'd1023, 1'b1, RES_FAULT});
        vec_rows.push_back('{C_MID, C_MID, C_MID, C_MID, 10'd1023, 10'd0, 1'b1, RES_FAULT});
        // Equal points on the left only
        vec_rows.push_back('{C_ZERO, C_ZERO, CAL_FAR_RST, CAL_NEAR_RST,
                             10'd100, 10'd900, 1'b0, '0});
        vec_rows.push_back('{C_ZERO, C_ZERO, CAL_FAR_RST, CAL_NEAR_RST,
                             10'd900, 10'd100, 1'b0, '0});
        // Right side pinned at the most negative value, then flipped
        vec_rows.push_back('{CAL_FAR_RST, CAL_NEAR_RST, C_TOP, C_TOP1,
                             10'd512, 10'd1023, 1'b0, '0});
        vec_rows.push_back('{CAL_FAR_RST, CAL_NEAR_RST, C_TOP, C_TOP1,
                             10'd0, 10'd1023, 1'b0, '0});
        // Both sides at the most negative value: heading clips low
        vec_rows.push_back('{C_TOP, C_TOP1, C_TOP, C_TOP1, 10'd1023, 10'd1023, 1'b0, '0});
        // Realistic calibration, inside and outside the wires
        vec_rows.push_back('{typ_far, typ_near, typ_far, typ_near,
                             10'd600, 10'd150, 1'b0, '0});
        vec_rows.push_back('{typ_far, typ_near, typ_far, typ_near,
                             10'd150, 10'd600, 1'b0, '0});
        vec_rows.push_back('{typ_far, typ_near, typ_far, typ_near,
                             10'd800, 10'd40, 1'b0, '0});
        vec_rows.push_back('{typ_far, typ_near, typ_far, typ_near,
                             10'd40, 10'd800, 1'b0, '0});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        cal_settings = 1;

        // Directed part
        rx_stall_pct = 25;
        foreach (vec_rows[k]) begin
            row = vec_rows[k];
            if (row.lf != cal_pts[REG_LEFT_CAL_FAR] || row.ln != cal_pts[REG_LEFT_CAL_NEAR] ||
                row.rf != cal_pts[REG_RIGHT_CAL_FAR] || row.rn != cal_pts[REG_RIGHT_CAL_NEAR])
                program_cal(row.lf, row.ln, row.rf, row.rn);
            send_pair(row.l, row.r, row.typed, row.want, gap_length(30));
        end

        // Random part: a new calibration setting and idle mix per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            choose_cal(ph, lf, ln, rf, rn);
            program_cal(lf, ln, rf, rn);
            if (ph == 0) begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end else begin
                tx_idle_pct = 20 * $urandom_range(0, 3);
                rx_stall_pct = 20 * $urandom_range(0, 3);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Let the pipeline run dry once in the middle of a phase
                if (ph == 4 && n == PHASE_ITEMS / 2) wait_drained();
                send_pair(pick_code(), pick_code(), 1'b0, '0, gap_length(tx_idle_pct));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d sample pairs under %0d calibration settings in %0d cycles",
                 items_sent, cal_settings, cycle_count);
        $display("checked %0d results: %0d outside the wires, %0d with a calibration fault",
                 results_checked, outside_seen, fault_seen);
        if (mismatch_count == 0) begin
            $display("dual_coil_wire_position_estimator: match");
        end else begin
            $display("%0d field mismatches", mismatch_count);
            $display("dual_coil_wire_position_estimator: mismatch");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, pos_expect_q.size());
        $display("dual_coil_wire_position_estimator: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/dcwpe_pkg.sv
design/dcwpe_div_pipe.sv
design/dcwpe_mix.sv
design/dcwpe_out_buf.sv
design/dual_coil_wire_position_estimator.sv
tb/sv/dual_coil_wire_position_estimator_tb.sv
